// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the line sensor reader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSPR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LSPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSPR_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/lspr_pkg.sv =====
// Types, constants and tables of the line sensor pulse reader.
package lspr_pkg;

    localparam int FRAME_BYTES = 3;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int BIT_W       = $clog2(FRAME_BITS);
    localparam int SHIFT_W     = 16;
    localparam int TICK_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX  = 3'd5;

    localparam logic [CFG_W-1:0] WAKE_LOW_RST  = 16'd980;
    localparam logic [CFG_W-1:0] WAKE_HIGH_RST = 16'd40;
    localparam logic [CFG_W-1:0] SETTLE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd6000;
    localparam logic [CFG_W-1:0] ZERO_MIN_RST  = 16'd50;
    localparam logic [CFG_W-1:0] ZERO_MAX_RST  = 16'd100;

    localparam int RAW_W = 6;
    localparam int POS_W = 6;
    localparam int SUM_W = 8;
    localparam int CNT_W = 3;
    localparam int IDX_W = 3;
    localparam int MAG_W = 7;
    localparam int STEP_W = 3;
    localparam int DIR_W = 2;

    localparam logic [IDX_W-1:0]  SUM_LAST = IDX_W'(RAW_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(MAG_W - 1);

    localparam logic signed [SUM_W-1:0] WEIGHT [RAW_W] = '{
        -8'sd30, -8'sd18, -8'sd6, 8'sd6, 8'sd18, 8'sd30
    };

    localparam logic [RAW_W-1:0] RAW_LEFT  = 6'd60;
    localparam logic [RAW_W-1:0] RAW_RIGHT = 6'd15;
    localparam logic [RAW_W-1:0] RAW_BOTH  = 6'd63;

    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_BOTH  = 2'd3;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_WAKE_LOW  = 8'b0000_0010,
        PH_WAKE_HIGH = 8'b0000_0100,
        PH_SETTLE    = 8'b0000_1000,
        PH_PRE_LOW   = 8'b0001_0000,
        PH_PRE_HIGH  = 8'b0010_0000,
        PH_BIT_LOW   = 8'b0100_0000,
        PH_BIT_HIGH  = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        CTL_RUN  = 2'b01,
        CTL_CALC = 2'b10
    } t_ctl;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_SUM  = 3'b010,
        C_DIV  = 3'b100
    } t_cstate;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] raw;
    } t_calc_req;

    typedef struct packed {
        logic                    done;
        logic signed [MAG_W-1:0] quotient;
    } t_calc_rsp;

endpackage

// ===== rtl/lspr_calc.sv =====
// Shared adder sequencer: weighted bit sum, bit count and serial division.
`include "assert_macros.svh"

module lspr_calc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lspr_pkg::t_calc_req   i_req,
    output lspr_pkg::t_calc_rsp   o_rsp
);

    lspr_pkg::t_cstate                          r_state;
    logic [lspr_pkg::RAW_W-1:0]                 r_raw;
    logic [lspr_pkg::IDX_W-1:0]                 r_idx;
    logic signed [lspr_pkg::SUM_W-1:0]          r_sum;
    logic [lspr_pkg::CNT_W-1:0]                 r_cnt;
    logic [lspr_pkg::MAG_W-1:0]                 r_mag;
    logic                                       r_neg;
    logic [lspr_pkg::CNT_W-1:0]                 r_rem;
    logic [lspr_pkg::STEP_W-1:0]                r_step;
    logic signed [lspr_pkg::MAG_W-1:0]          r_quo;
    logic                                       r_done;

    logic signed [lspr_pkg::SUM_W-1:0]          add_a;
    logic signed [lspr_pkg::SUM_W-1:0]          add_b;
    logic signed [lspr_pkg::SUM_W-1:0]          add_y;
    logic [lspr_pkg::CNT_W:0]                   trial;
    logic [lspr_pkg::CNT_W-1:0]                 n_cnt;
    logic [lspr_pkg::MAG_W-1:0]                 sum_abs;
    logic                                       ge;
    logic [lspr_pkg::MAG_W-1:0]                 n_mag;
    logic [lspr_pkg::CNT_W-1:0]                 n_rem;
    logic signed [lspr_pkg::MAG_W-1:0]          quo_final;
    logic signed [lspr_pkg::SUM_W-1:0]          w_sel;
    logic signed [lspr_pkg::SUM_W-1:0]          cnt_neg;

    assign trial   = {r_rem, r_mag[lspr_pkg::MAG_W-1]};
    assign w_sel   = r_raw[r_idx] ? lspr_pkg::WEIGHT[r_idx] : '0;
    assign cnt_neg = -$signed({{(lspr_pkg::SUM_W - lspr_pkg::CNT_W){1'b0}}, r_cnt});

    always_comb begin
        if (r_state == lspr_pkg::C_DIV) begin
            add_a = $signed({{(lspr_pkg::SUM_W - lspr_pkg::CNT_W - 1){1'b0}}, trial});
            add_b = cnt_neg;
        end else begin
            add_a = r_sum;
            add_b = w_sel;
        end
    end

    assign add_y     = add_a + add_b;
    assign n_cnt     = r_cnt + lspr_pkg::CNT_W'(r_raw[r_idx]);
    assign sum_abs   = add_y[lspr_pkg::SUM_W-1] ? lspr_pkg::MAG_W'(-add_y)
                                                : lspr_pkg::MAG_W'(add_y);
    assign ge        = !add_y[lspr_pkg::SUM_W-1];
    assign n_mag     = {r_mag[lspr_pkg::MAG_W-2:0], ge};
    assign n_rem     = ge ? add_y[lspr_pkg::CNT_W-1:0] : trial[lspr_pkg::CNT_W-1:0];
    assign quo_final = r_neg ? -$signed(n_mag) : $signed(n_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lspr_pkg::C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                lspr_pkg::C_IDLE: begin
                    if (i_req.start) begin
                        r_raw   <= i_req.raw;
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= lspr_pkg::C_SUM;
                    end
                end
                lspr_pkg::C_SUM: begin
                    r_sum <= add_y;
                    r_cnt <= n_cnt;
                    r_idx <= r_idx + lspr_pkg::IDX_W'(1);
                    if (r_idx == lspr_pkg::SUM_LAST) begin
                        r_mag   <= sum_abs;
                        r_neg   <= add_y[lspr_pkg::SUM_W-1];
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= lspr_pkg::C_DIV;
                    end
                end
                lspr_pkg::C_DIV: begin
                    r_mag  <= n_mag;
                    r_rem  <= n_rem;
                    r_step <= r_step + lspr_pkg::STEP_W'(1);
                    if (r_step == lspr_pkg::DIV_LAST) begin
                        r_quo   <= quo_final;
                        r_done  <= 1'b1;
                        r_state <= lspr_pkg::C_IDLE;
                    end
                end
                default: begin
                    r_state <= lspr_pkg::C_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `LSPR_ASSERT(a_rem_below_divisor, i_clk, i_rst_n, (r_state == lspr_pkg::C_DIV && r_cnt != '0) |-> (r_rem < r_cnt), "remainder not below divisor")
    `LSPR_ASSERT(a_cnt_bounded, i_clk, i_rst_n, (r_state == lspr_pkg::C_SUM) |-> (32'(r_cnt) <= 32'(r_idx)), "bit count exceeds bits visited")
    `LSPR_ASSERT(a_done_after_div, i_clk, i_rst_n, r_done |-> ($past(r_state) == lspr_pkg::C_DIV), "done without division")

endmodule

// ===== rtl/line_sensor_pulse_reader.sv =====
// Top level of the single-wire pulse-width line sensor reader.
// Each request is one microsecond tick (command, sampled pin level) and yields one result
// describing the line after that tick. An ordinary tick needs no arithmetic, so ticks can
// follow back to back while results are taken. The tick that closes a frame holds its result
// back while the shared adder of the arithmetic sequencer runs 6 accumulation steps over the
// sensor bits and then 7 restoring division steps for the line position.
`include "assert_macros.svh"

module line_sensor_pulse_reader (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic                               i_pin_level,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_drive_enable,
    output logic                               o_drive_level,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_reading_valid,
    output logic [lspr_pkg::RAW_W-1:0]         o_raw_pattern,
    output logic signed [lspr_pkg::POS_W-1:0]  o_line_position,
    output logic [lspr_pkg::DIR_W-1:0]         o_direction,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lspr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lspr_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [lspr_pkg::CFG_W-1:0]          r_wake_low;
    logic [lspr_pkg::CFG_W-1:0]          r_wake_high;
    logic [lspr_pkg::CFG_W-1:0]          r_settle;
    logic [lspr_pkg::CFG_W-1:0]          r_timeout;
    logic [lspr_pkg::CFG_W-1:0]          r_zero_min;
    logic [lspr_pkg::CFG_W-1:0]          r_zero_max;

    lspr_pkg::t_phase                    r_phase;
    lspr_pkg::t_phase                    n_phase;
    lspr_pkg::t_ctl                      r_ctl;
    logic [lspr_pkg::TICK_W-1:0]         r_tick;
    logic [lspr_pkg::TICK_W-1:0]         n_tick;
    logic [lspr_pkg::BIT_W-1:0]          r_bit;
    logic [lspr_pkg::BIT_W-1:0]          n_bit;
    logic [lspr_pkg::SHIFT_W-1:0]        r_shift;
    logic [lspr_pkg::SHIFT_W-1:0]        n_shift;
    logic [lspr_pkg::RAW_W-1:0]          r_raw;
    logic signed [lspr_pkg::POS_W-1:0]   r_pos;
    logic                                r_valid;
    logic                                r_done;
    logic                                r_out_valid;

    logic                                in_acc;
    logic                                finish;
    logic [lspr_pkg::TICK_W-1:0]         tick_inc;
    logic [lspr_pkg::TICK_W-1:0]         pulse_w;
    logic                                pulse_bit;
    logic                                shift_ok;
    logic [7:0]                          byte0;
    logic [7:0]                          byte1;
    logic [lspr_pkg::RAW_W-1:0]          frame_raw;
    logic [lspr_pkg::RAW_W:0]            run_chk;
    logic                                cmp_ok;
    logic                                shape_ok;
    lspr_pkg::t_calc_req                 calc_req;
    lspr_pkg::t_calc_rsp                 calc_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_ctl == lspr_pkg::CTL_RUN) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    assign tick_inc  = r_tick + lspr_pkg::TICK_W'(1);
    assign pulse_w   = i_pin_level ? tick_inc : r_tick;
    assign pulse_bit = !((pulse_w > r_zero_min) && (pulse_w < r_zero_max));
    assign shift_ok  = 32'(r_bit) < 32'(lspr_pkg::SHIFT_W);

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        finish  = 1'b0;
        unique case (r_phase)
            lspr_pkg::PH_IDLE: begin
                if (i_command) begin
                    n_phase = lspr_pkg::PH_WAKE_LOW;
                    n_tick  = '0;
                    n_bit   = '0;
                    n_shift = '0;
                end
            end
            lspr_pkg::PH_WAKE_LOW: begin
                if (tick_inc >= r_wake_low) begin
                    n_phase = lspr_pkg::PH_WAKE_HIGH;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            lspr_pkg::PH_WAKE_HIGH: begin
                if (tick_inc >= r_wake_high) begin
                    n_phase = lspr_pkg::PH_SETTLE;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            lspr_pkg::PH_SETTLE: begin
                if (tick_inc >= r_settle) begin
                    n_phase = lspr_pkg::PH_PRE_LOW;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            lspr_pkg::PH_PRE_LOW: begin
                if (i_pin_level || tick_inc >= r_timeout) begin
                    n_phase = lspr_pkg::PH_PRE_HIGH;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            lspr_pkg::PH_PRE_HIGH: begin
                if (!i_pin_level || tick_inc >= r_timeout) begin
                    n_phase = lspr_pkg::PH_BIT_LOW;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            lspr_pkg::PH_BIT_LOW: begin
                if (i_pin_level || tick_inc >= r_timeout) begin
                    n_phase = lspr_pkg::PH_BIT_HIGH;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            lspr_pkg::PH_BIT_HIGH: begin
                if (!i_pin_level || tick_inc >= r_timeout) begin
                    if (shift_ok) begin
                        n_shift = {r_shift[lspr_pkg::SHIFT_W-2:0], pulse_bit};
                    end
                    n_tick = '0;
                    if (r_bit == lspr_pkg::BIT_W'(lspr_pkg::FRAME_BITS - 1)) begin
                        finish  = 1'b1;
                        n_phase = lspr_pkg::PH_IDLE;
                        n_bit   = '0;
                    end else begin
                        n_phase = lspr_pkg::PH_BIT_LOW;
                        n_bit   = r_bit + lspr_pkg::BIT_W'(1);
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
            default: begin
                n_phase = lspr_pkg::PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    // frame check on the captured first two bytes
    assign byte0     = r_shift[15:8];
    assign byte1     = r_shift[7:0];
    assign frame_raw = byte0[lspr_pkg::RAW_W-1:0];
    assign run_chk   = ({1'b0, frame_raw} + {1'b0, frame_raw & (-frame_raw)})
                       & {1'b0, frame_raw};
    assign cmp_ok    = (byte1 == ~byte0);
    assign shape_ok  = (frame_raw != '0) && (run_chk == '0);

    assign calc_req.start = in_acc && finish;
    assign calc_req.raw   = n_shift[lspr_pkg::RAW_W+7:8];

    lspr_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (calc_req),
        .o_rsp   (calc_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_low  <= lspr_pkg::WAKE_LOW_RST;
            r_wake_high <= lspr_pkg::WAKE_HIGH_RST;
            r_settle    <= lspr_pkg::SETTLE_RST;
            r_timeout   <= lspr_pkg::TIMEOUT_RST;
            r_zero_min  <= lspr_pkg::ZERO_MIN_RST;
            r_zero_max  <= lspr_pkg::ZERO_MAX_RST;
            r_phase     <= lspr_pkg::PH_IDLE;
            r_ctl       <= lspr_pkg::CTL_RUN;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_raw       <= '0;
            r_pos       <= '0;
            r_valid     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lspr_pkg::CFG_WAKE_LOW:  r_wake_low  <= i_cfg_data;
                    lspr_pkg::CFG_WAKE_HIGH: r_wake_high <= i_cfg_data;
                    lspr_pkg::CFG_SETTLE:    r_settle    <= i_cfg_data;
                    lspr_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                    lspr_pkg::CFG_ZERO_MIN:  r_zero_min  <= i_cfg_data;
                    lspr_pkg::CFG_ZERO_MAX:  r_zero_max  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_done      <= finish;
                r_out_valid <= !finish;
            end else if (calc_rsp.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc && finish) begin
                r_ctl <= lspr_pkg::CTL_CALC;
            end else if (calc_rsp.done) begin
                r_ctl <= lspr_pkg::CTL_RUN;
            end

            if (calc_rsp.done) begin
                r_raw   <= cmp_ok ? frame_raw : '0;
                r_valid <= cmp_ok && shape_ok;
                r_pos   <= (cmp_ok && shape_ok) ? lspr_pkg::POS_W'(calc_rsp.quotient) : '0;
            end
        end
    end

    always_comb begin
        case (r_raw)
            lspr_pkg::RAW_LEFT:  o_direction = lspr_pkg::DIR_LEFT;
            lspr_pkg::RAW_RIGHT: o_direction = lspr_pkg::DIR_RIGHT;
            lspr_pkg::RAW_BOTH:  o_direction = lspr_pkg::DIR_BOTH;
            default:             o_direction = lspr_pkg::DIR_FWD;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_enable  = (r_phase == lspr_pkg::PH_WAKE_LOW)
                             || (r_phase == lspr_pkg::PH_WAKE_HIGH);
    assign o_drive_level   = (r_phase == lspr_pkg::PH_WAKE_HIGH);
    assign o_busy_res      = (r_phase != lspr_pkg::PH_IDLE);
    assign o_done_res      = r_done;
    assign o_reading_valid = r_valid;
    assign o_raw_pattern   = r_raw;
    assign o_line_position = r_pos;

    `LSPR_NEVER(a_no_result_while_calc, i_clk, i_rst_n, (r_ctl == lspr_pkg::CTL_CALC) && r_out_valid, "result shown during arithmetic")
    `LSPR_ASSERT(a_calc_done_expected, i_clk, i_rst_n, calc_rsp.done |-> (r_ctl == lspr_pkg::CTL_CALC), "unexpected arithmetic completion")
    `LSPR_ASSERT(a_idle_during_calc, i_clk, i_rst_n, (r_ctl == lspr_pkg::CTL_CALC) |-> (r_phase == lspr_pkg::PH_IDLE), "phase moved during arithmetic")
    `LSPR_ASSERT(a_valid_has_bits, i_clk, i_rst_n, r_valid |-> (r_raw != '0), "valid reading with empty pattern")

endmodule

// ===== verif/line_sensor_pulse_reader_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the line sensor pulse reader: reactive tick stimulus, predicted results.
module line_sensor_pulse_reader_tb;

    localparam logic [lspr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [lspr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [lspr_pkg::CFG_W-1:0]     CFG_MAX      = 16'hFFFF;
    localparam int TIMEOUT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 950;
    localparam int REPORT_LIMIT   = 10;
    localparam int LINE_WEIGHT [lspr_pkg::RAW_W] = '{-30, -18, -6, 6, 18, 30};

    typedef struct packed {
        logic                       drive_en;
        logic                       drive_lvl;
        logic                       busy;
        logic                       done;
        logic                       rvalid;
        logic [lspr_pkg::RAW_W-1:0] raw;
        logic [lspr_pkg::POS_W-1:0] pos;
        logic [lspr_pkg::DIR_W-1:0] dir;
    } t_tick_result;

    class t_reading_tracker;
        logic [lspr_pkg::CFG_W-1:0]   wake_low, wake_high, settle, timeout, zero_min, zero_max;
        lspr_pkg::t_phase             phase;
        logic [lspr_pkg::TICK_W-1:0]  tick_count;
        int                           bit_count;
        logic [lspr_pkg::SHIFT_W-1:0] frame;
        logic [lspr_pkg::RAW_W-1:0]   raw;
        int                           position;
        logic                         valid;
        t_tick_result                 due_results[$];
        int                           mismatch_count;

        function new();
            clear();
        endfunction

        function void clear();
            wake_low = lspr_pkg::WAKE_LOW_RST;
            wake_high = lspr_pkg::WAKE_HIGH_RST;
            settle = lspr_pkg::SETTLE_RST;
            timeout = lspr_pkg::TIMEOUT_RST;
            zero_min = lspr_pkg::ZERO_MIN_RST;
            zero_max = lspr_pkg::ZERO_MAX_RST;
            phase = lspr_pkg::PH_IDLE;
            tick_count = '0;
            bit_count = 0;
            frame = '0;
            raw = '0;
            position = 0;
            valid = 1'b0;
            due_results.delete();
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [lspr_pkg::CFG_IDX_W-1:0] idx,
                                logic [lspr_pkg::CFG_W-1:0] data);
            case (idx)
                lspr_pkg::CFG_WAKE_LOW:  wake_low = data;
                lspr_pkg::CFG_WAKE_HIGH: wake_high = data;
                lspr_pkg::CFG_SETTLE:    settle = data;
                lspr_pkg::CFG_TIMEOUT:   timeout = data;
                lspr_pkg::CFG_ZERO_MIN:  zero_min = data;
                lspr_pkg::CFG_ZERO_MAX:  zero_max = data;
                default: ;
            endcase
        endfunction

        function void enter(lspr_pkg::t_phase p);
            phase = p;
            tick_count = '0;
        endfunction

        function bit advance(logic [lspr_pkg::CFG_W-1:0] limit);
            tick_count = tick_count + 1'b1;
            return tick_count >= limit;
        endfunction

        function void close_frame();
            logic [7:0] b0, b1;
            int r, lowest, sum, cnt;
            b0 = frame[15:8];
            b1 = frame[7:0];
            raw = '0;
            position = 0;
            valid = 1'b0;
            if (b1 == ~b0) begin
                raw = b0[lspr_pkg::RAW_W-1:0];
                r = b0[lspr_pkg::RAW_W-1:0];
                lowest = r & -r;
                if (r != 0 && ((r + lowest) & r) == 0) begin
                    sum = 0;
                    cnt = 0;
                    for (int i = 0; i < lspr_pkg::RAW_W; i++) begin
                        if (r[i]) begin
                            sum += LINE_WEIGHT[i];
                            cnt++;
                        end
                    end
                    position = sum / cnt;
                    valid = 1'b1;
                end
            end
        endfunction

        function void accept_tick(logic cmd, logic pin);
            t_tick_result r;
            logic done_now, one;
            done_now = 1'b0;
            case (phase)
                lspr_pkg::PH_IDLE: begin
                    if (cmd) begin
                        enter(lspr_pkg::PH_WAKE_LOW);
                        bit_count = 0;
                        frame = '0;
                    end
                end
                lspr_pkg::PH_WAKE_LOW:  if (advance(wake_low)) enter(lspr_pkg::PH_WAKE_HIGH);
                lspr_pkg::PH_WAKE_HIGH: if (advance(wake_high)) enter(lspr_pkg::PH_SETTLE);
                lspr_pkg::PH_SETTLE:    if (advance(settle)) enter(lspr_pkg::PH_PRE_LOW);
                lspr_pkg::PH_PRE_LOW: begin
                    if (pin || advance(timeout)) enter(lspr_pkg::PH_PRE_HIGH);
                end
                lspr_pkg::PH_PRE_HIGH: begin
                    if (!pin || advance(timeout)) enter(lspr_pkg::PH_BIT_LOW);
                end
                lspr_pkg::PH_BIT_LOW: begin
                    if (pin || advance(timeout)) enter(lspr_pkg::PH_BIT_HIGH);
                end
                lspr_pkg::PH_BIT_HIGH: begin
                    if (!pin || advance(timeout)) begin
                        one = !(tick_count > zero_min && tick_count < zero_max);
                        if (bit_count < lspr_pkg::SHIFT_W) begin
                            frame = {frame[lspr_pkg::SHIFT_W-2:0], one};
                        end
                        bit_count++;
                        if (bit_count >= lspr_pkg::FRAME_BITS) begin
                            close_frame();
                            enter(lspr_pkg::PH_IDLE);
                            bit_count = 0;
                            done_now = 1'b1;
                        end else begin
                            enter(lspr_pkg::PH_BIT_LOW);
                        end
                    end
                end
                default: enter(lspr_pkg::PH_IDLE);
            endcase
            r.drive_en = (phase == lspr_pkg::PH_WAKE_LOW) || (phase == lspr_pkg::PH_WAKE_HIGH);
            r.drive_lvl = (phase == lspr_pkg::PH_WAKE_HIGH);
            r.busy = (phase != lspr_pkg::PH_IDLE);
            r.done = done_now;
            r.rvalid = valid;
            r.raw = raw;
            r.pos = lspr_pkg::POS_W'(position);
            if (raw == lspr_pkg::RAW_LEFT) r.dir = lspr_pkg::DIR_LEFT;
            else if (raw == lspr_pkg::RAW_RIGHT) r.dir = lspr_pkg::DIR_RIGHT;
            else if (raw == lspr_pkg::RAW_BOTH) r.dir = lspr_pkg::DIR_BOTH;
            else r.dir = lspr_pkg::DIR_FWD;
            due_results.push_back(r);
        endfunction

        function void match_result(t_tick_result got);
            t_tick_result want;
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result en=%b lvl=%b busy=%b done=%b valid=%b raw=%0d",
                             got.drive_en, got.drive_lvl, got.busy, got.done, got.rvalid,
                             got.raw);
                return;
            end
            want = due_results.pop_front();
            if (got.drive_en !== want.drive_en || got.drive_lvl !== want.drive_lvl ||
                got.busy !== want.busy || got.done !== want.done ||
                got.rvalid !== want.rvalid || got.raw !== want.raw ||
                got.pos !== want.pos || got.dir !== want.dir) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("mismatch exp: en=%b lvl=%b busy=%b done=%b valid=%b raw=%0d pos=%0d dir=%0d",
                             want.drive_en, want.drive_lvl, want.busy, want.done, want.rvalid,
                             want.raw, $signed(want.pos), want.dir);
                    $display("         got: en=%b lvl=%b busy=%b done=%b valid=%b raw=%0d pos=%0d dir=%0d",
                             got.drive_en, got.drive_lvl, got.busy, got.done, got.rvalid,
                             got.raw, $signed(got.pos), got.dir);
                end
            end
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               i_command = 1'b0;
    logic                               i_pin_level = 1'b0;
    logic                               i_out_ready = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [lspr_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [lspr_pkg::CFG_W-1:0]         i_cfg_data = '0;
    logic                               o_in_ready, o_out_valid, o_cfg_ready;
    logic                               o_drive_enable, o_drive_level, o_busy_res, o_done_res;
    logic                               o_reading_valid;
    logic [lspr_pkg::RAW_W-1:0]         o_raw_pattern;
    logic signed [lspr_pkg::POS_W-1:0]  o_line_position;
    logic [lspr_pkg::DIR_W-1:0]         o_direction;

    t_reading_tracker tracker = new();
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int sent_ticks = 0;

    line_sensor_pulse_reader dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_pin_level     (i_pin_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_enable  (o_drive_enable),
        .o_drive_level   (o_drive_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_reading_valid (o_reading_valid),
        .o_raw_pattern   (o_raw_pattern),
        .o_line_position (o_line_position),
        .o_direction     (o_direction),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pulse_width(logic one);
        int lo, hi;
        lo = tracker.zero_min;
        hi = tracker.zero_max;
        if (!one && hi > lo + 1) return $urandom_range(lo + 1, (hi - 1 < lo + 6) ? hi - 1 : lo + 6);
        if (one && hi <= 24 && $urandom_range(0, 1) == 1) return $urandom_range(hi, hi + 2);
        return $urandom_range(0, (lo < 6) ? lo : 6);
    endfunction

    function automatic logic [lspr_pkg::FRAME_BITS-1:0] random_frame();
        logic [7:0] b0, b1;
        int s, n;
        b0 = 8'($urandom);
        case ($urandom_range(0, 5))
            0: begin
                s = $urandom_range(0, lspr_pkg::RAW_W - 1);
                n = $urandom_range(1, lspr_pkg::RAW_W - s);
                b0[lspr_pkg::RAW_W-1:0] = lspr_pkg::RAW_W'(((1 << n) - 1) << s);
            end
            1: b0[lspr_pkg::RAW_W-1:0] = lspr_pkg::RAW_LEFT;
            2: b0[lspr_pkg::RAW_W-1:0] = lspr_pkg::RAW_RIGHT;
            3: b0[lspr_pkg::RAW_W-1:0] = lspr_pkg::RAW_BOTH;
            4: b0[lspr_pkg::RAW_W-1:0] = '0;
            default: ;
        endcase
        b1 = ($urandom_range(0, 6) == 0) ? 8'($urandom) : ~b0;
        return {b0, b1, 8'($urandom)};
    endfunction

    task automatic send_tick(input logic cmd, input logic pin);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_pin_level <= pin;
        do @(posedge i_clk); while (!o_in_ready);
        sent_ticks++;
        tracker.accept_tick(cmd, pin);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [lspr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lspr_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [lspr_pkg::CFG_W-1:0] wl,
                                input logic [lspr_pkg::CFG_W-1:0] wh,
                                input logic [lspr_pkg::CFG_W-1:0] st,
                                input logic [lspr_pkg::CFG_W-1:0] to,
                                input logic [lspr_pkg::CFG_W-1:0] zmn,
                                input logic [lspr_pkg::CFG_W-1:0] zmx,
                                input bit spare);
        write_cfg(lspr_pkg::CFG_WAKE_LOW, wl);
        write_cfg(lspr_pkg::CFG_WAKE_HIGH, wh);
        write_cfg(lspr_pkg::CFG_SETTLE, st);
        write_cfg(lspr_pkg::CFG_TIMEOUT, to);
        write_cfg(lspr_pkg::CFG_ZERO_MIN, zmn);
        write_cfg(lspr_pkg::CFG_ZERO_MAX, zmx);
        if (spare) begin
            write_cfg(CFG_SPARE_LO, 16'($urandom));
            write_cfg(CFG_SPARE_HI, 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_random();
        logic [lspr_pkg::CFG_W-1:0] to, zmn, zmx;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) to = 16'($urandom_range(8, 30));
        else if (r < 85) to = 16'($urandom_range(1, 4));
        else to = CFG_MAX;
        zmn = ($urandom_range(0, 9) == 0) ? CFG_MAX : 16'($urandom_range(0, 3));
        zmx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : zmn + 16'($urandom_range(0, 5));
        program_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                     16'($urandom_range(0, 3)), to, zmn, zmx, $urandom_range(0, 3) == 0);
    endtask

    // Follow the predicted phase so that preamble and pulses land where the frame asks.
    task automatic run_reading(input logic [lspr_pkg::FRAME_BITS-1:0] frame_bits);
        bit started;
        int width;
        logic cmd, pin;
        started = 1'b0;
        width = 0;
        while (!(started && tracker.phase == lspr_pkg::PH_IDLE)) begin
            cmd = 1'($urandom_range(0, 1));
            pin = 1'($urandom_range(0, 1));
            case (tracker.phase)
                lspr_pkg::PH_IDLE: begin
                    cmd = 1'b1;
                    started = 1'b1;
                end
                lspr_pkg::PH_PRE_HIGH: pin = ($urandom_range(0, 2) != 0);
                lspr_pkg::PH_BIT_LOW: begin
                    width = pulse_width(frame_bits[lspr_pkg::FRAME_BITS-1-tracker.bit_count]);
                end
                lspr_pkg::PH_BIT_HIGH: pin = (tracker.tick_count < width);
                default: ;
            endcase
            send_tick(cmd, pin);
        end
    endtask

    task automatic run_stuck(input logic level);
        send_tick(1'b1, level);
        while (tracker.phase != lspr_pkg::PH_IDLE) send_tick(1'($urandom_range(0, 1)), level);
    endtask

    task automatic run_noise(input int count);
        repeat (count) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic finish_reading();
        while (tracker.phase != lspr_pkg::PH_IDLE)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin : result_sink
        int stall_left;
        t_tick_result seen;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                seen.drive_en = o_drive_enable;
                seen.drive_lvl = o_drive_level;
                seen.busy = o_busy_res;
                seen.done = o_done_res;
                seen.rvalid = o_reading_valid;
                seen.raw = o_raw_pattern;
                seen.pos = o_line_position;
                seen.dir = o_direction;
                tracker.match_result(seen);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        drain_results();

        program_regs(16'd1, 16'd1, 16'd0, CFG_MAX, 16'd0, 16'd2, 1'b1);
        run_reading({8'h3C, 8'hC3, 8'h5A});
        run_reading({8'h0F, 8'hF0, 8'h00});
        run_reading({8'h00, 8'hFF, 8'h81});
        run_reading({8'h2D, 8'hD2, 8'h33});
        run_reading({8'h21, 8'h00, 8'h00});
        run_reading({8'h20, 8'hDF, 8'h7E});
        drain_results();

        // long wake with every wait cut short
        quiet = 1'b1;
        program_regs(16'd30, 16'd1, 16'd0, 16'd1, CFG_MAX, 16'd0, 1'b0);
        run_stuck(1'($urandom_range(0, 1)));
        drain_results();
        quiet = 1'b0;

        program_random();
        hold_request = 1'b1;
        while (sent_ticks < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                finish_reading();
                drain_results();
                program_random();
            end
            quiet = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) run_reading(random_frame());
            else if (pick < 8 && tracker.timeout <= 16) run_stuck(1'($urandom_range(0, 1)));
            else run_noise($urandom_range(4, 40));
        end
        quiet = 1'b0;

        drain_results();
        if (tracker.mismatch_count == 0 && tracker.due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lspr_pkg.sv
rtl/lspr_calc.sv
rtl/line_sensor_pulse_reader.sv
verif/line_sensor_pulse_reader_tb.sv
